// ----- rtl/i2cbm_pkg.sv -----
package i2cbm_pkg;

    // Width of the phase hold counter
    localparam int DELAY_W = 16;

    // Command codes carried by an input item
    localparam logic [2:0] CMD_START = 3'd0;
    localparam logic [2:0] CMD_STOP  = 3'd1;
    localparam logic [2:0] CMD_WRITE = 3'd2;
    localparam logic [2:0] CMD_WACK  = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    // Hold lengths in microseconds
    localparam logic [1:0] HOLD_1US = 2'd0;
    localparam logic [1:0] HOLD_2US = 2'd1;
    localparam logic [1:0] HOLD_4US = 2'd2;

    // Register reset values
    localparam logic [7:0] TICKS_PER_US_RST = 8'd50;
    localparam logic [7:0] ACK_TIMEOUT_RST  = 8'd250;

    // Configuration register indexes
    localparam logic REG_TICKS_PER_US = 1'b0;
    localparam logic REG_ACK_TIMEOUT  = 1'b1;

    typedef struct packed {
        logic [7:0] ticks_per_us;
        logic [7:0] ack_timeout;
    } cfg_t;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] command;
        logic [7:0] write_data;
        logic       send_ack;
        logic       sda_in;
    } cmd_t;

    typedef struct packed {
        logic       ack_failed;
        logic [7:0] read_data;
        logic       done_res;
        logic       busy_res;
        logic       sda_is_output;
        logic       sda_level;
        logic       scl_level;
    } res_t;

    // Hold length: 1, 2 or 4 times ticks_per_us; at most 1020, so it always fits DELAY_W
    function automatic logic [DELAY_W-1:0] hold_len(input logic [7:0] tpu,
                                                   input logic [1:0] us_sel);
        logic [9:0] n;
        begin
            case (us_sel)
                HOLD_2US: n = {1'b0, tpu, 1'b0};
                HOLD_4US: n = {tpu, 2'b00};
                default:  n = {2'b00, tpu};
            endcase
            hold_len = DELAY_W'(n);
        end
    endfunction

endpackage

// ----- rtl/i2cbm_seq.sv -----
module i2cbm_seq
    import i2cbm_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic step_en,
    input  cmd_t cmd,
    input  cfg_t cfg,
    output res_t res_next
);

    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_START    = 4'd1;
    localparam logic [3:0] PH_STOP_LO  = 4'd2;
    localparam logic [3:0] PH_STOP_HI  = 4'd3;
    localparam logic [3:0] PH_ACK_SET  = 4'd4;
    localparam logic [3:0] PH_ACK_HI   = 4'd5;
    localparam logic [3:0] PH_ACK_POLL = 4'd6;
    localparam logic [3:0] PH_SND_SET  = 4'd7;
    localparam logic [3:0] PH_SND_HI   = 4'd8;
    localparam logic [3:0] PH_SND_LO   = 4'd9;
    localparam logic [3:0] PH_RD_LO    = 4'd10;
    localparam logic [3:0] PH_RD_HI    = 4'd11;
    localparam logic [3:0] PH_RACK_LO  = 4'd12;
    localparam logic [3:0] PH_RACK_HI  = 4'd13;

    logic [3:0]         phase_reg, phase_next;
    logic [3:0]         bit_reg, bit_next;
    logic [7:0]         shift_reg, shift_next;
    logic [DELAY_W-1:0] delay_reg, delay_next;
    logic [7:0]         poll_reg, poll_next;
    logic               scl_reg, scl_next;
    logic               sda_reg, sda_next;
    logic               oe_reg, oe_next;
    logic               ackm_reg, ackm_next;
    logic [7:0]         rdata_reg, rdata_next;
    logic               fail_reg, fail_next;
    logic               done;

    always_comb begin
        phase_next = phase_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        delay_next = delay_reg;
        poll_next  = poll_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        oe_next    = oe_reg;
        ackm_next  = ackm_reg;
        rdata_next = rdata_reg;
        fail_next  = fail_reg;
        done       = 1'b0;

        case (phase_reg)
            PH_IDLE: begin
                if (cmd.cmd_valid) begin
                    case (cmd.command)
                        CMD_START: begin
                            oe_next    = 1'b1;
                            scl_next   = 1'b1;
                            sda_next   = 1'b0;
                            delay_next = hold_len(cfg.ticks_per_us, HOLD_4US);
                            phase_next = PH_START;
                        end
                        CMD_STOP: begin
                            oe_next    = 1'b1;
                            scl_next   = 1'b0;
                            sda_next   = 1'b0;
                            delay_next = hold_len(cfg.ticks_per_us, HOLD_4US);
                            phase_next = PH_STOP_LO;
                        end
                        CMD_WRITE: begin
                            oe_next    = 1'b1;
                            bit_next   = 4'd0;
                            sda_next   = cmd.write_data[7];
                            shift_next = {cmd.write_data[6:0], 1'b0};
                            delay_next = hold_len(cfg.ticks_per_us, HOLD_2US);
                            phase_next = PH_SND_SET;
                        end
                        CMD_WACK: begin
                            oe_next    = 1'b0;
                            sda_next   = 1'b1;
                            fail_next  = 1'b0;
                            delay_next = hold_len(cfg.ticks_per_us, HOLD_1US);
                            phase_next = PH_ACK_SET;
                        end
                        CMD_READ: begin
                            oe_next    = 1'b0;
                            sda_next   = 1'b1;
                            scl_next   = 1'b0;
                            shift_next = 8'd0;
                            bit_next   = 4'd0;
                            ackm_next  = cmd.send_ack;
                            delay_next = hold_len(cfg.ticks_per_us, HOLD_2US);
                            phase_next = PH_RD_LO;
                        end
                        default: ;
                    endcase
                end
            end
            PH_ACK_POLL: begin
                if (!cmd.sda_in) begin
                    scl_next   = 1'b0;
                    fail_next  = 1'b0;
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end else if (poll_reg >= cfg.ack_timeout) begin
                    // give up: flag failure and release the bus with a stop
                    fail_next  = 1'b1;
                    oe_next    = 1'b1;
                    scl_next   = 1'b0;
                    sda_next   = 1'b0;
                    delay_next = hold_len(cfg.ticks_per_us, HOLD_4US);
                    phase_next = PH_STOP_LO;
                end else begin
                    poll_next = poll_reg + 8'd1;
                end
            end
            default: begin
                if (delay_reg > DELAY_W'(1)) begin
                    delay_next = delay_reg - DELAY_W'(1);
                end else begin
                    case (phase_reg)
                        PH_START: begin
                            scl_next   = 1'b0;
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                        PH_STOP_LO: begin
                            scl_next   = 1'b1;
                            sda_next   = 1'b1;
                            delay_next = hold_len(cfg.ticks_per_us, HOLD_4US);
                            phase_next = PH_STOP_HI;
                        end
                        PH_STOP_HI: begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                        PH_ACK_SET: begin
                            scl_next   = 1'b1;
                            delay_next = hold_len(cfg.ticks_per_us, HOLD_1US);
                            phase_next = PH_ACK_HI;
                        end
                        PH_ACK_HI: begin
                            poll_next  = 8'd0;
                            phase_next = PH_ACK_POLL;
                        end
                        PH_SND_SET: begin
                            scl_next   = 1'b1;
                            delay_next = hold_len(cfg.ticks_per_us, HOLD_2US);
                            phase_next = PH_SND_HI;
                        end
                        PH_SND_HI: begin
                            scl_next   = 1'b0;
                            delay_next = hold_len(cfg.ticks_per_us, HOLD_2US);
                            phase_next = PH_SND_LO;
                        end
                        PH_SND_LO: begin
                            bit_next = bit_reg + 4'd1;
                            if (bit_next >= 4'd8) begin
                                phase_next = PH_IDLE;
                                done       = 1'b1;
                            end else begin
                                sda_next   = shift_reg[7];
                                shift_next = {shift_reg[6:0], 1'b0};
                                delay_next = hold_len(cfg.ticks_per_us, HOLD_2US);
                                phase_next = PH_SND_SET;
                            end
                        end
                        PH_RD_LO: begin
                            // sample on the rising SCL edge
                            scl_next   = 1'b1;
                            shift_next = {shift_reg[6:0], cmd.sda_in};
                            delay_next = hold_len(cfg.ticks_per_us, HOLD_1US);
                            phase_next = PH_RD_HI;
                        end
                        PH_RD_HI: begin
                            bit_next   = bit_reg + 4'd1;
                            scl_next   = 1'b0;
                            delay_next = hold_len(cfg.ticks_per_us, HOLD_2US);
                            if (bit_next >= 4'd8) begin
                                rdata_next = shift_reg;
                                oe_next    = 1'b1;
                                sda_next   = ~ackm_reg;
                                phase_next = PH_RACK_LO;
                            end else begin
                                phase_next = PH_RD_LO;
                            end
                        end
                        PH_RACK_LO: begin
                            scl_next   = 1'b1;
                            delay_next = hold_len(cfg.ticks_per_us, HOLD_2US);
                            phase_next = PH_RACK_HI;
                        end
                        PH_RACK_HI: begin
                            scl_next   = 1'b0;
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                        default: phase_next = PH_IDLE;
                    endcase
                end
            end
        endcase
    end

    always_comb begin
        res_next.scl_level     = scl_next;
        res_next.sda_level     = sda_next;
        res_next.sda_is_output = oe_next;
        res_next.busy_res      = (phase_next != PH_IDLE);
        res_next.done_res      = done;
        res_next.read_data     = rdata_next;
        res_next.ack_failed    = fail_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            bit_reg   <= 4'd0;
            shift_reg <= 8'd0;
            delay_reg <= '0;
            poll_reg  <= 8'd0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            oe_reg    <= 1'b1;
            ackm_reg  <= 1'b0;
            rdata_reg <= 8'd0;
            fail_reg  <= 1'b0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            delay_reg <= delay_next;
            poll_reg  <= poll_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            oe_reg    <= oe_next;
            ackm_reg  <= ackm_next;
            rdata_reg <= rdata_next;
            fail_reg  <= fail_next;
        end
    end

endmodule

// ----- rtl/i2c_bus_master.sv -----
// Result: registered, shown in the cycle after the tick's input transfer.
// Throughput: one tick per cycle unless the result stalls; sequencer state steps
//   once per transfer; the result register frees up as soon as it is taken.
// Reset: synchronous, active-low aresetn; bus released (SCL and SDA high,
//   SDA driven), sequencer idle, registers back to 50 ticks/us and 250 polls.
module i2c_bus_master
    import i2cbm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input ticks
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // command[2:0], write_data[10:3], send_ack[11],
                                   // sda_in[12], zero[15:13]
    input  logic        s_tuser,   // cmd_valid[0]
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // scl_level[0], sda_level[1], sda_is_output[2],
                                   // busy_res[3], done_res[4], read_data[12:5],
                                   // ack_failed[13], zero[15:14]
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t cfg_reg;
    cmd_t cmd;
    res_t res_next;
    res_t res_reg;
    logic m_tvalid_reg;
    logic s_xfer;
    logic cfg_wr;

    // Accept a new tick whenever the result register is empty or being drained
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;

    // Unpack the input transfer
    always_comb begin
        cmd.cmd_valid  = s_tuser;
        cmd.command    = s_tdata[2:0];
        cmd.write_data = s_tdata[10:3];
        cmd.send_ack   = s_tdata[11];
        cmd.sda_in     = s_tdata[12];
    end

    // Bus sequencer: state advances only on an accepted tick
    i2cbm_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (s_xfer),
        .cmd      (cmd),
        .cfg      (cfg_reg),
        .res_next (res_next)
    );

    // Result register: valid bit under reset, payload loaded on each transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_xfer) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, res_reg};

    // APB register file; bit 2 of the address picks the register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ticks_per_us <= TICKS_PER_US_RST;
            cfg_reg.ack_timeout  <= ACK_TIMEOUT_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_TICKS_PER_US: cfg_reg.ticks_per_us <= pwdata[7:0];
                REG_ACK_TIMEOUT:  cfg_reg.ack_timeout  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_TICKS_PER_US: prdata = {24'd0, cfg_reg.ticks_per_us};
            REG_ACK_TIMEOUT:  prdata = {24'd0, cfg_reg.ack_timeout};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

// ----- rtl/i2cbm_chk.sv -----
module i2cbm_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // Tick flow: ready follows the result register's occupancy
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow result occupancy");

    // Every accepted tick shows a result in the next cycle
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted tick gave no result");

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // An operation that finishes is no longer busy
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[4] && m_tdata[3]))
        else $error("done and busy together");

endmodule

bind i2c_bus_master i2cbm_chk u_i2cbm_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
